/* rtl/slcdtx_pkg.sv */
// shared types, constants and byte sequence functions for the serial lcd
// command transmitter; no dependencies
package slcdtx_pkg;

  localparam int LINE_CHARS = 16;
  localparam int SEQ_MAX    = LINE_CHARS + 2;
  localparam int BPOS_W     = $clog2(SEQ_MAX + 1);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] BYTE_CMD     = 8'hFE;
  localparam logic [7:0] POS_BASE     = 8'h80;
  localparam logic [7:0] ROW2_OFS     = 8'h30;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] CLR_CODE     = 8'h01;
  localparam logic [7:0] BL_CMD       = 8'h7C;
  localparam logic [7:0] BL_VAL       = 8'd157;
  localparam logic [7:0] ROW_LEN      = 8'd16;
  localparam logic [7:0] TWO_ROWS     = 8'd32;
  localparam logic [7:0] BIT_TIME_DEF = 8'd102;
  localparam logic [7:0] BIT_TIME_MIN = 8'd96;
  localparam logic [7:0] BIT_TIME_MAX = 8'd108;
  localparam logic [7:0] AUTOTUNE_RST = 8'd51;

  localparam logic [0:0] REG_AUTOTUNE = 1'b0;

  typedef enum logic [2:0] {
    MODE_CHAR      = 3'd0,
    MODE_GOTO      = 3'd1,
    MODE_CLRLINE   = 3'd2,
    MODE_CLEAR     = 3'd3,
    MODE_BACKLIGHT = 3'd4,
    MODE_TICK      = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    OP_CMD,
    OP_TICK,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] kind;
    logic [7:0] arg;
  } item_t;

  typedef struct packed {
    logic accepted;
    logic busy_res;
    logic tx_level;
  } result_t;

  function automatic logic [BPOS_W-1:0] seq_len(input logic [2:0] kind);
    logic [BPOS_W-1:0] n;
    if (kind == MODE_CHAR) begin
      n = BPOS_W'(1);
    end else if (kind == MODE_CLRLINE) begin
      n = BPOS_W'(SEQ_MAX);
    end else begin
      n = BPOS_W'(2);
    end
    return n;
  endfunction

  function automatic logic [7:0] seq_byte(input logic [2:0] kind, input logic [7:0] arg,
                                          input logic [BPOS_W-1:0] pos);
    logic [7:0] b;
    unique case (kind)
      MODE_CHAR: b = arg;
      MODE_GOTO: begin
        if (pos == '0) b = BYTE_CMD;
        else if (arg < ROW_LEN) b = arg + POS_BASE;
        else if (arg < TWO_ROWS) b = arg + POS_BASE + ROW2_OFS;
        else b = POS_BASE;
      end
      MODE_CLRLINE: begin
        if (pos == '0) b = BYTE_CMD;
        else if (pos == BPOS_W'(1)) b = {arg[3:0], 4'h0} | POS_BASE;
        else b = SPACE_CHAR;
      end
      MODE_CLEAR: b = (pos == '0) ? BYTE_CMD : CLR_CODE;
      default:    b = (pos == '0) ? BL_CMD : BL_VAL;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] bit_time(input logic [7:0] tune);
    logic [7:0] t;
    t = {tune[6:0], 1'b0};
    if (t < BIT_TIME_MIN || t > BIT_TIME_MAX) t = BIT_TIME_DEF;
    return t;
  endfunction

endpackage

/* rtl/serial_lcd_command_transmitter_core.sv */
// Serial display command transmitter, 8N1, least significant bit first.
// Each input transfer is a command (character, cursor position, clear line,
// clear display, backlight), a one-microsecond tick or a no-op (modes 6, 7);
// every transfer yields exactly one result transfer with the line level, the
// busy flag and whether a command was taken (commands are refused while a
// sequence is in progress). One transfer is accepted every cycle while the
// output is not stalled; its result passes the input register, the two-entry
// queue and the result register. The back end's byte sequencer and bit timer
// advance on tick items only. Bit time is twice the low seven bits of the
// autotune register (address 0, reset 51), replaced by 102 outside 96..108.
module serial_lcd_command_transmitter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // argument
  input  logic [2:0]  s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // tx_level, busy_res, accepted, zero fill
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import slcdtx_pkg::*;

  logic    [7:0] autotune_q;
  logic          fr_valid, fr_ready, bk_valid, bk_ready;
  item_t         fr_item, bk_item;
  result_t       res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_AUTOTUNE) ? {24'b0, autotune_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      autotune_q <= AUTOTUNE_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_AUTOTUNE) begin
      autotune_q <= pwdata[7:0];
    end
  end

  slcdtx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .mode_i       (s_axis_tuser),
    .arg_i        (s_axis_tdata),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  slcdtx_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_item_o   (bk_item)
  );

  slcdtx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .autotune_i   (autotune_q),
    .item_valid_i (bk_valid),
    .item_ready_o (bk_ready),
    .item_i       (bk_item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {5'b0, res};

endmodule

/* rtl/slcdtx_front.sv */
// front end: takes input transfers, classifies them into command, tick or
// no-op and holds them for the queue; uses slcdtx_pkg
module slcdtx_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         mode_i,
  input  logic [7:0]         arg_i,
  output logic               item_valid_o,
  input  logic               item_ready_i,
  output slcdtx_pkg::item_t  item_o
);
  import slcdtx_pkg::*;

  logic  vld_q, vld_d;
  item_t item_q, item_d;
  op_e   op;

  always_comb begin
    if (mode_i == MODE_TICK) op = OP_TICK;
    else if (mode_i <= MODE_BACKLIGHT) op = OP_CMD;
    else op = OP_NOP;
  end

  assign in_ready_o = !vld_q || item_ready_i;

  always_comb begin
    vld_d  = vld_q && !item_ready_i;
    item_d = item_q;
    if (in_valid_i && in_ready_o) begin
      vld_d  = 1'b1;
      item_d = '{op: op, kind: mode_i, arg: arg_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

endmodule

/* rtl/slcdtx_fifo.sv */
// short queue of classified items between front and back end;
// uses slcdtx_pkg
module slcdtx_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  slcdtx_pkg::item_t  push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output slcdtx_pkg::item_t  pop_item_o
);
  import slcdtx_pkg::*;

  item_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  push, pop;

  assign push_ready_o = cnt_q != FIFO_CNT_W'(FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      if (push && !pop) cnt_q <= cnt_q + FIFO_CNT_W'(1);
      else if (pop && !push) cnt_q <= cnt_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_item_i;
  end

endmodule

/* rtl/slcdtx_back.sv */
// back end: byte sequencer and 8n1 bit timer, one item per cycle unless the
// output stalls, with a result register toward the output; uses slcdtx_pkg
module slcdtx_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           autotune_i,
  input  logic                 item_valid_i,
  output logic                 item_ready_o,
  input  slcdtx_pkg::item_t    item_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output slcdtx_pkg::result_t  res_o
);
  import slcdtx_pkg::*;

  localparam logic [3:0] STOP_BIT = 4'd9;

  logic [2:0]        kind_q, kind_d;
  logic [7:0]        arg_q, arg_d;
  logic [BPOS_W-1:0] byte_pos_q, byte_pos_d, pos_nxt;
  logic [7:0]        cur_byte_q, cur_byte_d;
  logic [3:0]        bit_pos_q, bit_pos_d;
  logic [6:0]        tick_q, tick_d;
  logic [7:0]        tick_nxt;
  logic              sending_q, sending_d;
  logic              res_valid_q, res_valid_d;
  result_t           res_q, res_d;
  logic              pop, take, level;
  logic [2:0]        bit_idx;

  assign item_ready_o = !res_valid_q || res_ready_i;
  assign pop          = item_valid_i && item_ready_o;
  assign take         = item_i.op == OP_CMD && !sending_q;
  assign bit_idx      = 3'(bit_pos_q - 4'd1);
  assign tick_nxt     = {1'b0, tick_q} + 8'd1;
  assign pos_nxt      = byte_pos_q + BPOS_W'(1);

  always_comb begin
    if (!sending_q) level = 1'b1;
    else if (bit_pos_q == '0) level = 1'b0;
    else if (bit_pos_q >= STOP_BIT) level = 1'b1;
    else level = cur_byte_q[bit_idx];
  end

  always_comb begin
    kind_d      = kind_q;
    arg_d       = arg_q;
    byte_pos_d  = byte_pos_q;
    cur_byte_d  = cur_byte_q;
    bit_pos_d   = bit_pos_q;
    tick_d      = tick_q;
    sending_d   = sending_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_d       = res_q;
    if (pop) begin
      res_valid_d = 1'b1;
      if (take) begin
        res_d      = '{accepted: 1'b1, busy_res: 1'b1, tx_level: 1'b0};
        kind_d     = item_i.kind;
        arg_d      = item_i.arg;
        byte_pos_d = '0;
        bit_pos_d  = '0;
        tick_d     = '0;
        cur_byte_d = seq_byte(item_i.kind, item_i.arg, '0);
        sending_d  = 1'b1;
      end else begin
        res_d = '{accepted: 1'b0, busy_res: sending_q, tx_level: level};
        if (item_i.op == OP_TICK && sending_q) begin
          if (tick_nxt >= bit_time(autotune_i)) begin
            tick_d = '0;
            if (bit_pos_q == STOP_BIT) begin
              bit_pos_d = '0;
              if (pos_nxt >= seq_len(kind_q)) begin
                sending_d  = 1'b0;
                byte_pos_d = '0;
              end else begin
                byte_pos_d = pos_nxt;
                cur_byte_d = seq_byte(kind_q, arg_q, pos_nxt);
              end
            end else begin
              bit_pos_d = bit_pos_q + 4'd1;
            end
          end else begin
            tick_d = tick_nxt[6:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q  <= '0;
      bit_pos_q   <= '0;
      tick_q      <= '0;
      sending_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      byte_pos_q  <= byte_pos_d;
      bit_pos_q   <= bit_pos_d;
      tick_q      <= tick_d;
      sending_q   <= sending_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    arg_q      <= arg_d;
    cur_byte_q <= cur_byte_d;
    res_q      <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/slcdtx_checker.sv */
// port-level checks for the serial lcd command transmitter and the bind
// that attaches them to the top level; no package use
module slcdtx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // a taken command starts its start bit at once
  a_take_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1] && !m_axis_tdata[0])
    else $error("accepted command without start bit");

  // idle line is high
  a_idle_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("line low while idle");

  // register reads back the last write
  a_reg_rdback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $past(psel && penable && pwrite && pready && paddr[2] == 1'b0)
      && paddr[2] == 1'b0 |-> prdata == {24'b0, $past(pwdata[7:0])})
    else $error("register read back mismatch");

endmodule

bind serial_lcd_command_transmitter_core slcdtx_checker u_slcdtx_checker (.*);

/* tb/sv/tb_slcdtx_line_checker.sv */
// line checker for the serial lcd command transmitter: follows the input, result
// and register transfers, predicts the line level, busy flag and taken flag per item
// depends on slcdtx_pkg
`timescale 1ns / 100ps

module tb_slcdtx_line_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic [2:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          mismatches_o,
  output int          outstanding_o
);
  import slcdtx_pkg::*;

  localparam logic [2:0] TUNE_ADDR = {REG_AUTOTUNE, 2'b00};

  logic [7:0] tune;
  logic [2:0] seq_kind;
  logic [7:0] seq_arg;
  logic [4:0] byte_pos;
  logic [7:0] cur_byte;
  logic [3:0] bit_pos;
  logic [6:0] tick_cnt;
  logic       sending;

  result_t    expected_line_q[$];
  result_t    got;
  result_t    want;
  logic [2:0] mode;
  logic [7:0] arg;

  function automatic int frame_len(input logic [2:0] kind);
    if (kind == MODE_CHAR) return 1;
    if (kind == MODE_CLRLINE) return LINE_CHARS + 2;
    return 2;
  endfunction

  function automatic logic [7:0] frame_byte(input logic [2:0] kind, input logic [7:0] a,
                                            input int pos);
    logic [11:0] wide;
    logic [7:0]  b;
    case (kind)
      MODE_CHAR: b = a;
      MODE_GOTO: begin
        if (pos == 0) b = BYTE_CMD;
        else if (a < 8'd16) b = a + 8'h80;
        else if (a < 8'd32) b = a + 8'hB0;
        else b = POS_BASE;
      end
      MODE_CLRLINE: begin
        wide = {4'h0, a} << 4;
        if (pos == 0) b = BYTE_CMD;
        else if (pos == 1) b = wide[7:0] | POS_BASE;
        else b = SPACE_CHAR;
      end
      MODE_CLEAR: b = (pos == 0) ? BYTE_CMD : CLR_CODE;
      default:    b = (pos == 0) ? BL_CMD : BL_VAL;
    endcase
    return b;
  endfunction

  function automatic int ticks_per_bit(input logic [7:0] t);
    logic [7:0] d;
    d = t << 1;
    if (d < BIT_TIME_MIN || d > BIT_TIME_MAX) return int'(BIT_TIME_DEF);
    return int'(d);
  endfunction

  function automatic logic level_now();
    if (!sending) return 1'b1;
    if (bit_pos == 4'd0) return 1'b0;
    if (bit_pos >= 4'd9) return 1'b1;
    return cur_byte[bit_pos - 4'd1];
  endfunction

  task automatic advance_line_model(input logic [2:0] m, input logic [7:0] a);
    result_t r;
    r = '0;
    if (m == MODE_TICK) begin
      r.tx_level = level_now();
      r.busy_res = sending;
      if (sending) begin
        if (int'(tick_cnt) + 1 >= ticks_per_bit(tune)) begin
          tick_cnt = '0;
          bit_pos  = bit_pos + 4'd1;
          if (bit_pos >= 4'd10) begin
            bit_pos  = '0;
            byte_pos = byte_pos + 5'd1;
            if (int'(byte_pos) >= frame_len(seq_kind)) begin
              sending  = 1'b0;
              byte_pos = '0;
            end else begin
              cur_byte = frame_byte(seq_kind, seq_arg, int'(byte_pos));
            end
          end
        end else begin
          tick_cnt = tick_cnt + 7'd1;
        end
      end
    end else begin
      if (m <= MODE_BACKLIGHT && !sending) begin
        seq_kind   = m;
        seq_arg    = a;
        byte_pos   = '0;
        bit_pos    = '0;
        tick_cnt   = '0;
        cur_byte   = frame_byte(m, a, 0);
        sending    = 1'b1;
        r.accepted = 1'b1;
      end
      r.tx_level = level_now();
      r.busy_res = sending;
    end
    expected_line_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tune     = AUTOTUNE_RST;
      seq_kind = '0;
      seq_arg  = '0;
      byte_pos = '0;
      cur_byte = '0;
      bit_pos  = '0;
      tick_cnt = '0;
      sending  = 1'b0;
      expected_line_q.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = result_t'(m_tdata_i[2:0]);
        if (expected_line_q.size() == 0) begin
          if (mismatches_o < 10)
            $display("%0t: result transfer with nothing expected: level %0b busy %0b taken %0b",
                     $realtime, got.tx_level, got.busy_res, got.accepted);
          mismatches_o++;
        end else begin
          want = expected_line_q.pop_front();
          if (got.tx_level !== want.tx_level || got.busy_res !== want.busy_res ||
              got.accepted !== want.accepted) begin
            if (mismatches_o < 10)
              $display("%0t: mismatch: expected level %0b busy %0b taken %0b, got %0b %0b %0b",
                       $realtime, want.tx_level, want.busy_res, want.accepted,
                       got.tx_level, got.busy_res, got.accepted);
            mismatches_o++;
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == TUNE_ADDR)
        tune = pwdata_i[7:0];
      if (s_tvalid_i && s_tready_i) begin
        mode = s_tuser_i;
        arg  = s_tdata_i;
        advance_line_model(mode, arg);
      end
      outstanding_o = expected_line_q.size();
    end
  end

endmodule

/* tb/sv/tb_serial_lcd_command_transmitter_core.sv */
// testbench top for serial_lcd_command_transmitter_core: drives commands, ticks and
// tuning writes with random gaps and output stalls, and reports the verdict
// depends on slcdtx_pkg, the core and tb_slcdtx_line_checker
`timescale 1ns / 100ps

module tb_serial_lcd_command_transmitter_core;
  import slcdtx_pkg::*;

  localparam logic [2:0] TUNE_ADDR     = {REG_AUTOTUNE, 2'b00};
  localparam logic [2:0] MODE_RSVD_LO  = 3'd6;
  localparam logic [2:0] MODE_RSVD_HI  = 3'd7;
  localparam int         ITEM_COUNT    = 850;
  localparam int         TAIL_TICKS    = 40;
  localparam int         CYCLE_LIMIT   = 200_000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // argument
  logic [2:0]  s_axis_tuser;   // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;   // tx_level, busy_res, accepted, zero fill
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          outstanding;
  int          burst_left;
  int          sent;
  int          cycles;
  logic [10:0] rx_cycle = '0;

  serial_lcd_command_transmitter_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  tb_slcdtx_line_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("serial_lcd_command_transmitter_core verification failed");
      $finish;
    end
  end

  // output stall style changes with bits 9:8 of rx_cycle
  always @(negedge clk_i) begin
    logic rdy;
    case (rx_cycle[9:8])
      2'd0:    rdy = 1'b1;
      2'd1:    rdy = ($urandom_range(0, 3) != 0);
      2'd2:    rdy = (rx_cycle[2:0] != 3'd5);
      default: rdy = 1'($urandom_range(0, 1));
    endcase
    m_axis_tready <= rdy;
    rx_cycle      <= rx_cycle + 11'd1;
  end

  task automatic send(input logic [2:0] mode, input logic [7:0] arg);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 24);
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= arg;
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    burst_left--;
    sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send(MODE_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic write_tune(input logic [7:0] value);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TUNE_ADDR;
    pwdata  <= {24'h0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    burst_left = 0;
  endtask

  function automatic logic [7:0] pick_tune();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd47;
      3:       return 8'd55;
      4:       return 8'd176;
      5:       return 8'd182;
      6:       return 8'd48;
      7:       return 8'd54;
      8:       return 8'($urandom_range(48, 54));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [2:0] mode;
    logic [7:0] arg;
    int         r;
    int         n;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    burst_left    = 0;
    sent          = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // unused modes, idle tick, one taken command then refusals while busy
    send(MODE_RSVD_LO, 8'hFF);
    send(MODE_RSVD_HI, 8'h00);
    send(MODE_TICK, 8'hFF);
    send(MODE_CHAR, 8'hFF);
    send(MODE_GOTO, 8'h00);
    send(MODE_CLRLINE, 8'hFF);
    send(MODE_CLEAR, 8'h00);
    send(MODE_BACKLIGHT, 8'hFF);
    send(MODE_RSVD_LO, 8'h00);
    send_ticks(3);
    // tuning changes mid-bit, out of range at both ends, then at the lower bound
    write_tune(8'hFF);
    send_ticks(3);
    write_tune(8'h00);
    send_ticks(3);
    write_tune(8'd48);
    send_ticks(3);

    while (sent < ITEM_COUNT - TAIL_TICKS) begin
      if ($urandom_range(0, 11) == 0) write_tune(pick_tune());
      r = $urandom_range(0, 99);
      if (r < 25) mode = MODE_CHAR;
      else if (r < 40) mode = MODE_GOTO;
      else if (r < 48) mode = MODE_CLRLINE;
      else if (r < 63) mode = MODE_CLEAR;
      else if (r < 78) mode = MODE_BACKLIGHT;
      else if (r < 85) mode = $urandom_range(0, 1) ? MODE_RSVD_LO : MODE_RSVD_HI;
      else mode = MODE_TICK;
      if (mode == MODE_GOTO && $urandom_range(0, 1)) arg = 8'($urandom_range(0, 40));
      else arg = 8'($urandom_range(0, 255));
      send(mode, arg);
      r = $urandom_range(0, 99);
      if (r < 75) n = $urandom_range(0, 12);
      else if (r < 95) n = $urandom_range(20, 120);
      else n = $urandom_range(150, 300);
      if (n > ITEM_COUNT - TAIL_TICKS - sent) n = ITEM_COUNT - TAIL_TICKS - sent;
      send_ticks(n);
    end
    write_tune(AUTOTUNE_RST);
    send_ticks(TAIL_TICKS);

    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    if (mismatches == 0)
      $display("serial_lcd_command_transmitter_core verification clean");
    else
      $display("serial_lcd_command_transmitter_core verification failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/slcdtx_pkg.sv
rtl/slcdtx_front.sv
rtl/slcdtx_fifo.sv
rtl/slcdtx_back.sv
rtl/serial_lcd_command_transmitter_core.sv
rtl/slcdtx_checker.sv
tb/sv/tb_slcdtx_line_checker.sv
tb/sv/tb_serial_lcd_command_transmitter_core.sv
